// ===== sv/trl_pkg.sv =====
// Shared types and constants of the transpose ranking list.
package trl_pkg;

   localparam int FUNC_BITS   = 3;
   localparam int KEY_BITS    = 32;
   localparam int RANK_BITS   = 5;
   localparam int STATUS_BITS = 2;
   localparam int PLACE_BITS  = 5;
   localparam int COUNT_BITS  = 5;

   // A read of the top never streams more words than this.
   localparam logic [RANK_BITS-1:0] TOP_LIMIT = 5'd16;

   typedef enum logic [FUNC_BITS-1:0] {
      FN_APPEND   = 3'd0,
      FN_ADD      = 3'd1,
      FN_CONTAINS = 3'd2,
      FN_GET_RANK = 3'd3,
      FN_MOVE_DN  = 3'd4,
      FN_POSITION = 3'd5,
      FN_READ_TOP = 3'd6
   } func_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_FETCH_A,
      S_FETCH_B,
      S_FETCH_C,
      S_SWAP_LO,
      S_SWAP_HI,
      S_APPEND,
      S_TOP_ISSUE,
      S_TOP_DATA,
      S_RESP
   } state_type;

endpackage

// ===== sv/trl_req_if.sv =====
// Request channel of the transpose ranking list.
interface trl_req_if
   import trl_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [FUNC_BITS-1:0] func;
   logic [KEY_BITS-1:0]  key;
   logic [RANK_BITS-1:0] rank;

   modport source (output valid, output func, output key, output rank, input ready);
   modport sink (input valid, input func, input key, input rank, output ready);
endinterface

// ===== sv/trl_rsp_if.sv =====
// Response channel of the transpose ranking list.
interface trl_rsp_if
   import trl_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [KEY_BITS-1:0]    data;
   logic [PLACE_BITS-1:0]  place;
   logic [COUNT_BITS-1:0]  count;
   logic                   last;

   modport source (output valid, output status, output data, output place, output count,
                   output last, input ready);
   modport sink (input valid, input status, input data, input place, input count,
                 input last, output ready);
endinterface

// ===== sv/trl_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module trl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== sv/transpose_ranking_list.sv =====
// Self-organizing ranking table with the transpose rule. Keys live in one RAM with a single
// read port and a single write port, so a scan walks that RAM one entry per cycle. A lookup
// (add, contains, position) scans from rank one. Two writes follow when the found key trades
// places with its predecessor, and add appends a missing key after the scan. Append writes
// the key after the last entry; get by rank and move down fetch two neighbouring entries and
// swap them, but get by rank at rank one skips the swap. A read of the top loads each word
// into the output register once the previous word has been taken, and waits while the
// consumer does not keep up. One item is worked at a time; the next request is taken once
// the previous response word sits in the output register, even if that word has not yet
// been taken.
module transpose_ranking_list
   import trl_pkg::*;
#(
   parameter int CAPACITY  = 16,
   parameter int KEY_WIDTH = 32
) (
   input  logic  clock,
   input  logic  reset,
   trl_req_if.sink   req_if,
   trl_rsp_if.source rsp_if
);
   // Stored key width: the key field carries 32 bits at most.
   localparam int SW = (KEY_WIDTH < KEY_BITS) ? KEY_WIDTH : KEY_BITS;
   localparam int IW = $clog2(CAPACITY);
   localparam int FW = $clog2(CAPACITY + 1);
   localparam int CW = (FW > RANK_BITS) ? FW : RANK_BITS;

   state_type                state_ff, state_in;
   func_type                 op_ff, op_in;
   logic [SW-1:0]            key_ff, key_in;
   logic [RANK_BITS-1:0]     rank_ff, rank_in;
   logic [RANK_BITS-1:0]     top_n_ff, top_n_in;
   logic [FW-1:0]            fill_ff, fill_in;
   logic [FW-1:0]            idx_ff, idx_in;
   logic [FW-1:0]            cidx_ff, cidx_in;
   logic                     chk_ff, chk_in;
   logic [IW-1:0]            lo_ff, lo_in;
   logic [SW-1:0]            a_ff, a_in;
   logic [SW-1:0]            b_ff, b_in;
   status_type               status_ff, status_in;
   logic [KEY_BITS-1:0]      data_ff, data_in;
   logic [PLACE_BITS-1:0]    place_ff, place_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [KEY_BITS-1:0]      rsp_data_ff, rsp_data_in;
   logic [PLACE_BITS-1:0]    rsp_place_ff, rsp_place_in;
   logic [COUNT_BITS-1:0]    rsp_count_ff, rsp_count_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     ram_wr_en;
   logic [IW-1:0]            ram_wr_addr;
   logic [SW-1:0]            ram_wr_data;
   logic                     ram_rd_en;
   logic [IW-1:0]            ram_rd_addr;
   logic [SW-1:0]            ram_rd_data;

   logic                     req_fire;
   logic                     rsp_free;
   logic                     is_full;
   logic                     is_empty;
   logic [CW-1:0]            rank_cw;
   logic [CW-1:0]            fill_cw;
   logic [CW-1:0]            top_cw;
   logic [RANK_BITS-1:0]     top_n;
   logic                     get_bad;
   logic                     move_bad;
   logic                     scan_issue;
   logic                     scan_hit;
   logic                     scan_end;
   logic                     top_last;
   func_type                 req_func;

   trl_ram #(
      .WIDTH (SW),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign req_func     = func_type'(req_if.func);
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;

   assign is_full  = (fill_ff == FW'(CAPACITY));
   assign is_empty = (fill_ff == '0);
   assign rank_cw  = CW'(req_if.rank);
   assign fill_cw  = CW'(fill_ff);
   assign get_bad  = (req_if.rank == '0) || (rank_cw > fill_cw);
   assign move_bad = (req_if.rank == '0) || (rank_cw >= fill_cw);
   assign top_cw   = (rank_cw < fill_cw) ? rank_cw : fill_cw;
   assign top_n    = (top_cw > CW'(TOP_LIMIT)) ? TOP_LIMIT : RANK_BITS'(top_cw);

   // The scan keeps one read in flight; the word compared belongs to cidx_ff.
   assign scan_issue = (idx_ff < fill_ff);
   assign scan_hit   = chk_ff && (ram_rd_data == key_ff);
   assign scan_end   = chk_ff && !scan_hit && ((cidx_ff + FW'(1)) == fill_ff);
   assign top_last   = ((RANK_BITS'(idx_ff) + RANK_BITS'(1)) == top_n_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_func)
                  FN_APPEND:   state_in = is_full ? S_RESP : S_APPEND;
                  FN_ADD:      state_in = is_empty ? S_APPEND : S_SCAN;
                  FN_CONTAINS,
                  FN_POSITION: state_in = is_empty ? S_RESP : S_SCAN;
                  FN_GET_RANK: state_in = get_bad ? S_RESP : S_FETCH_A;
                  FN_MOVE_DN:  state_in = move_bad ? S_RESP : S_FETCH_A;
                  FN_READ_TOP: state_in = (top_n == '0) ? S_RESP : S_TOP_ISSUE;
                  default:     state_in = S_RESP;
               endcase
            end
         end
         S_SCAN: begin
            priority if (scan_hit) begin
               state_in = ((op_ff == FN_POSITION) || (cidx_ff == '0)) ? S_RESP : S_SWAP_LO;
            end else if (scan_end) begin
               state_in = ((op_ff == FN_ADD) && !is_full) ? S_APPEND : S_RESP;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_FETCH_A: state_in = S_FETCH_B;
         S_FETCH_B: state_in = S_FETCH_C;
         S_FETCH_C: begin
            state_in = ((op_ff == FN_GET_RANK) && (rank_ff == RANK_BITS'(1))) ? S_RESP
                                                                              : S_SWAP_LO;
         end
         S_SWAP_LO:   state_in = S_SWAP_HI;
         S_SWAP_HI:   state_in = S_RESP;
         S_APPEND:    state_in = S_RESP;
         S_TOP_ISSUE: state_in = S_TOP_DATA;
         S_TOP_DATA: begin
            if (rsp_free) begin
               state_in = top_last ? S_IDLE : S_TOP_ISSUE;
            end
         end
         S_RESP: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath, memory controls and response word.
   always_comb begin
      op_in     = op_ff;
      key_in    = key_ff;
      rank_in   = rank_ff;
      top_n_in  = top_n_ff;
      fill_in   = fill_ff;
      idx_in    = idx_ff;
      cidx_in   = cidx_ff;
      chk_in    = chk_ff;
      lo_in     = lo_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      status_in = status_ff;
      data_in   = data_ff;
      place_in  = place_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_place_in  = rsp_place_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = lo_ff;
      ram_wr_data = b_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = lo_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in     = req_func;
               key_in    = req_if.key[SW-1:0];
               rank_in   = req_if.rank;
               top_n_in  = top_n;
               idx_in    = '0;
               chk_in    = 1'b0;
               status_in = ST_OK;
               data_in   = '0;
               place_in  = '0;
               lo_in     = '0;
               unique case (req_func)
                  FN_APPEND: begin
                     if (is_full) begin
                        status_in = ST_FULL;
                     end
                  end
                  FN_ADD: begin
                  end
                  FN_CONTAINS,
                  FN_POSITION: begin
                     if (is_empty) begin
                        status_in = ST_MISS;
                     end
                  end
                  FN_GET_RANK: begin
                     if (get_bad) begin
                        status_in = ST_MISS;
                     end else if (req_if.rank != RANK_BITS'(1)) begin
                        lo_in = IW'(rank_cw - CW'(2));
                     end
                  end
                  FN_MOVE_DN: begin
                     if (move_bad) begin
                        status_in = ST_MISS;
                     end else begin
                        lo_in = IW'(rank_cw - CW'(1));
                     end
                  end
                  FN_READ_TOP: begin
                     if (top_n == '0) begin
                        status_in = ST_MISS;
                     end
                  end
                  default: status_in = ST_MISS;
               endcase
            end
         end
         S_SCAN: begin
            ram_rd_en   = scan_issue;
            ram_rd_addr = idx_ff[IW-1:0];
            if (scan_issue) begin
               idx_in = idx_ff + FW'(1);
            end
            chk_in  = scan_issue && !scan_hit && !scan_end;
            cidx_in = idx_ff;
            if (scan_hit) begin
               chk_in   = 1'b0;
               place_in = PLACE_BITS'(cidx_ff) + PLACE_BITS'(1);
               lo_in    = IW'(cidx_ff - FW'(1));
               b_in     = ram_rd_data;
            end else if (chk_ff) begin
               // Keep the entry just ahead of the next compare for a possible swap.
               a_in = ram_rd_data;
               if (scan_end) begin
                  if (op_ff != FN_ADD) begin
                     status_in = ST_MISS;
                  end else if (is_full) begin
                     status_in = ST_FULL;
                  end
               end
            end
         end
         S_FETCH_A: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = lo_ff;
         end
         S_FETCH_B: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = lo_ff + IW'(1);
            a_in        = ram_rd_data;
         end
         S_FETCH_C: begin
            b_in = ram_rd_data;
            if (op_ff == FN_GET_RANK) begin
               data_in = (rank_ff == RANK_BITS'(1)) ? KEY_BITS'(a_ff) : KEY_BITS'(ram_rd_data);
            end
         end
         S_SWAP_LO: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = lo_ff;
            ram_wr_data = b_ff;
         end
         S_SWAP_HI: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = lo_ff + IW'(1);
            ram_wr_data = a_ff;
         end
         S_APPEND: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = fill_ff[IW-1:0];
            ram_wr_data = key_ff;
            fill_in     = fill_ff + FW'(1);
         end
         S_TOP_ISSUE: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_ff[IW-1:0];
         end
         S_TOP_DATA: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_data_in   = KEY_BITS'(ram_rd_data);
               rsp_place_in  = PLACE_BITS'(idx_ff) + PLACE_BITS'(1);
               rsp_count_in  = COUNT_BITS'(fill_ff);
               rsp_last_in   = top_last;
               idx_in        = idx_ff + FW'(1);
            end
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_data_in   = data_ff;
               rsp_place_in  = place_ff;
               rsp_count_in  = COUNT_BITS'(fill_ff);
               rsp_last_in   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      rank_ff       <= rank_in;
      top_n_ff      <= top_n_in;
      idx_ff        <= idx_in;
      cidx_ff       <= cidx_in;
      lo_ff         <= lo_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      status_ff     <= status_in;
      data_ff       <= data_in;
      place_ff      <= place_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_place_ff  <= rsp_place_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.status = rsp_status_ff;
   assign rsp_if.data   = rsp_data_ff;
   assign rsp_if.place  = rsp_place_ff;
   assign rsp_if.count  = rsp_count_ff;
   assign rsp_if.last   = rsp_last_ff;

   // The table never holds more keys than it has room for.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(CAPACITY))
      else $error("fill count beyond capacity");

   // Reads and writes of the key memory never share a cycle.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("key memory read and written in the same cycle");

   // An append grows the table by exactly one key.
   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPEND) |=> (fill_ff == $past(fill_ff) + FW'(1)))
      else $error("append did not grow the table by one");

   // A compared word always comes from a held entry.
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && chk_ff) |-> (cidx_ff < fill_ff))
      else $error("scan compared an entry beyond the fill count");

   // A swap touches two held entries.
   a_swap_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWAP_LO) |-> ((FW'(lo_ff) + FW'(1)) < fill_ff))
      else $error("swap pair lies beyond the fill count");
endmodule
